// ===== hdl/snfcs_pkg.sv =====
`default_nettype none
package snfcs_pkg;
   localparam int BLOCK_SHIFT = 15;
   localparam int PAGE_BYTES = 256;
   localparam int NUM_REGS = 8;
   localparam int MAX_RESULTS = 8;

   localparam logic [3:0] REQ_SECTOR_ERASE = 4'd0;
   localparam logic [3:0] REQ_BLOCK_ERASE = 4'd1;
   localparam logic [3:0] REQ_CHIP_ERASE = 4'd2;
   localparam logic [3:0] REQ_RANGE_ERASE = 4'd3;
   localparam logic [3:0] REQ_PAGE_PROGRAM = 4'd4;
   localparam logic [3:0] REQ_BYTE_PROGRAM = 4'd5;
   localparam logic [3:0] REQ_DATA_BYTE = 4'd6;
   localparam logic [3:0] REQ_READ = 4'd7;
   localparam logic [3:0] REQ_ID_CHECK = 4'd8;
   localparam logic [3:0] REQ_SPI_RESPONSE = 4'd9;

   localparam logic [2:0] ACT_SEND = 3'd0;
   localparam logic [2:0] ACT_RECV = 3'd1;
   localparam logic [2:0] ACT_RELEASE = 3'd2;
   localparam logic [2:0] ACT_HOST = 3'd3;
   localparam logic [2:0] ACT_DONE = 3'd4;
   localparam logic [2:0] ACT_REJECT = 3'd5;

   localparam logic [2:0] REG_WRITE_ENABLE = 3'd0;
   localparam logic [2:0] REG_READ_STATUS = 3'd1;
   localparam logic [2:0] REG_SECTOR_ERASE = 3'd2;
   localparam logic [2:0] REG_BLOCK_ERASE = 3'd3;
   localparam logic [2:0] REG_CHIP_ERASE = 3'd4;
   localparam logic [2:0] REG_PAGE_PROGRAM = 3'd5;
   localparam logic [2:0] REG_READ_DATA = 3'd6;
   localparam logic [2:0] REG_READ_ID = 3'd7;

   localparam logic [7:0] STATUS_WEL = 8'h02;
   localparam logic [7:0] STATUS_WIP = 8'h01;

   localparam logic [3:0][7:0] ID_EXPECT = {8'h00, 8'h18, 8'h20, 8'hC2};
   localparam logic [7:0][7:0] CFG_RESET =
      {8'h9F, 8'h03, 8'h02, 8'h60, 8'h52, 8'h20, 8'h05, 8'h06};

   typedef logic [7:0][7:0] cfg_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] out_byte;
      logic id_match;
   } result_type;

   typedef struct packed {
      logic [3:0] count;
      result_type [MAX_RESULTS-1:0] item;
   } batch_type;

   function automatic batch_type emit(batch_type b, logic [2:0] act, logic [7:0] data,
                                      logic match);
      batch_type r;
      r = b;
      if (r.count < 4'(MAX_RESULTS)) begin
         r.item[r.count[2:0]].action = act;
         r.item[r.count[2:0]].out_byte = data;
         r.item[r.count[2:0]].id_match = match;
         r.count = r.count + 4'd1;
      end
      return r;
   endfunction

   function automatic batch_type emit_addr(batch_type b, logic [23:0] a);
      batch_type r;
      r = emit(b, ACT_SEND, a[23:16], 1'b0);
      r = emit(r, ACT_SEND, a[15:8], 1'b0);
      r = emit(r, ACT_SEND, a[7:0], 1'b0);
      return r;
   endfunction

   function automatic batch_type emit_poll(batch_type b, logic [7:0] op);
      batch_type r;
      r = emit(b, ACT_SEND, op, 1'b0);
      r = emit(r, ACT_RECV, 8'd0, 1'b0);
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/snfcs_front.sv =====
`default_nettype none
module snfcs_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire logic [3:0] req_type,
   input  wire logic [23:0] req_byte_address,
   input  wire logic [8:0] req_block_index,
   input  wire logic [9:0] req_block_count,
   input  wire logic [6:0] req_page_index,
   input  wire logic [15:0] req_transfer_length,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [7:0] req_rx_byte,
   input  wire snfcs_pkg::cfg_type cfg,
   output snfcs_pkg::batch_type batch
);
   typedef enum logic [2:0] {
      IDLE, WAIT_WEL, PROG_DATA, WAIT_WIP, READ_DATA, ID_READ
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [3:0] op_ff, op_in;
   logic [23:0] addr_ff, addr_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [9:0] blk_ff, blk_in;
   logic [9:0] brem_ff, brem_in;
   logic [1:0] idc_ff, idc_in;
   logic ideq_ff, ideq_in;

   always_comb begin
      snfcs_pkg::batch_type b;
      logic eq;
      b = '0;
      eq = 1'b0;
      phase_in = phase_ff;
      op_in = op_ff;
      addr_in = addr_ff;
      bytes_in = bytes_ff;
      blk_in = blk_ff;
      brem_in = brem_ff;
      idc_in = idc_ff;
      ideq_in = ideq_ff;
      if (req_type <= snfcs_pkg::REQ_ID_CHECK && req_type != snfcs_pkg::REQ_DATA_BYTE
          && phase_ff == IDLE) begin
         op_in = req_type;
         case (req_type)
            snfcs_pkg::REQ_RANGE_ERASE: begin
               blk_in = {1'b0, req_block_index};
               brem_in = req_block_count;
               if (req_block_count == 10'd0) begin
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_DONE, 8'd0, 1'b0);
               end else begin
                  addr_in = 24'(blk_in) << snfcs_pkg::BLOCK_SHIFT;
               end
            end
            snfcs_pkg::REQ_PAGE_PROGRAM: begin
               addr_in = (24'(req_block_index) << snfcs_pkg::BLOCK_SHIFT)
                         + 24'(req_page_index) * 24'(snfcs_pkg::PAGE_BYTES);
               bytes_in = 16'(snfcs_pkg::PAGE_BYTES);
            end
            snfcs_pkg::REQ_BYTE_PROGRAM, snfcs_pkg::REQ_READ: begin
               addr_in = req_byte_address;
               bytes_in = req_transfer_length;
            end
            snfcs_pkg::REQ_ID_CHECK: begin
               idc_in = 2'd0;
               ideq_in = 1'b1;
            end
            default: addr_in = req_byte_address;
         endcase
         if (req_type == snfcs_pkg::REQ_READ) begin
            b = snfcs_pkg::emit(b, snfcs_pkg::ACT_SEND, cfg[snfcs_pkg::REG_READ_DATA], 1'b0);
            b = snfcs_pkg::emit_addr(b, req_byte_address);
            if (req_transfer_length == 16'd0) begin
               b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
               b = snfcs_pkg::emit(b, snfcs_pkg::ACT_DONE, 8'd0, 1'b0);
            end else begin
               b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RECV, 8'd0, 1'b0);
               phase_in = READ_DATA;
            end
         end else if (req_type == snfcs_pkg::REQ_ID_CHECK) begin
            b = snfcs_pkg::emit(b, snfcs_pkg::ACT_SEND, cfg[snfcs_pkg::REG_READ_ID], 1'b0);
            b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RECV, 8'd0, 1'b0);
            phase_in = ID_READ;
         end else if (!(req_type == snfcs_pkg::REQ_RANGE_ERASE
                        && req_block_count == 10'd0)) begin
            b = snfcs_pkg::emit(b, snfcs_pkg::ACT_SEND,
                                cfg[snfcs_pkg::REG_WRITE_ENABLE], 1'b0);
            b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
            b = snfcs_pkg::emit_poll(b, cfg[snfcs_pkg::REG_READ_STATUS]);
            phase_in = WAIT_WEL;
         end
      end else if (req_type == snfcs_pkg::REQ_DATA_BYTE && phase_ff == PROG_DATA) begin
         b = snfcs_pkg::emit(b, snfcs_pkg::ACT_SEND, req_data_byte, 1'b0);
         bytes_in = bytes_ff - 16'd1;
         if (bytes_in == 16'd0) begin
            b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
            b = snfcs_pkg::emit_poll(b, cfg[snfcs_pkg::REG_READ_STATUS]);
            phase_in = WAIT_WIP;
         end
      end else if (req_type == snfcs_pkg::REQ_SPI_RESPONSE && phase_ff != IDLE
                   && phase_ff != PROG_DATA) begin
         unique case (phase_ff)
            WAIT_WEL: begin
               b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
               if ((req_rx_byte & snfcs_pkg::STATUS_WEL) == 8'd0) begin
                  b = snfcs_pkg::emit_poll(b, cfg[snfcs_pkg::REG_READ_STATUS]);
               end else if (op_ff == snfcs_pkg::REQ_CHIP_ERASE) begin
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_SEND,
                                      cfg[snfcs_pkg::REG_CHIP_ERASE], 1'b0);
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
                  b = snfcs_pkg::emit_poll(b, cfg[snfcs_pkg::REG_READ_STATUS]);
                  phase_in = WAIT_WIP;
               end else if (op_ff == snfcs_pkg::REQ_SECTOR_ERASE
                            || op_ff == snfcs_pkg::REQ_BLOCK_ERASE
                            || op_ff == snfcs_pkg::REQ_RANGE_ERASE) begin
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_SEND,
                                      op_ff == snfcs_pkg::REQ_SECTOR_ERASE
                                      ? cfg[snfcs_pkg::REG_SECTOR_ERASE]
                                      : cfg[snfcs_pkg::REG_BLOCK_ERASE], 1'b0);
                  b = snfcs_pkg::emit_addr(b, addr_ff);
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
                  b = snfcs_pkg::emit_poll(b, cfg[snfcs_pkg::REG_READ_STATUS]);
                  phase_in = WAIT_WIP;
               end else begin
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_SEND,
                                      cfg[snfcs_pkg::REG_PAGE_PROGRAM], 1'b0);
                  b = snfcs_pkg::emit_addr(b, addr_ff);
                  if (bytes_ff == 16'd0) begin
                     b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
                     b = snfcs_pkg::emit_poll(b, cfg[snfcs_pkg::REG_READ_STATUS]);
                     phase_in = WAIT_WIP;
                  end else begin
                     phase_in = PROG_DATA;
                  end
               end
            end
            WAIT_WIP: begin
               b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
               if ((req_rx_byte & snfcs_pkg::STATUS_WIP) != 8'd0) begin
                  b = snfcs_pkg::emit_poll(b, cfg[snfcs_pkg::REG_READ_STATUS]);
               end else if (op_ff == snfcs_pkg::REQ_RANGE_ERASE
                            && brem_ff != 10'd1) begin
                  blk_in = blk_ff + 10'd1;
                  brem_in = brem_ff - 10'd1;
                  addr_in = 24'(blk_in) << snfcs_pkg::BLOCK_SHIFT;
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_SEND,
                                      cfg[snfcs_pkg::REG_WRITE_ENABLE], 1'b0);
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
                  b = snfcs_pkg::emit_poll(b, cfg[snfcs_pkg::REG_READ_STATUS]);
                  phase_in = WAIT_WEL;
               end else begin
                  if (op_ff == snfcs_pkg::REQ_RANGE_ERASE) begin
                     blk_in = blk_ff + 10'd1;
                     brem_in = brem_ff - 10'd1;
                  end
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_DONE, 8'd0, 1'b0);
                  phase_in = IDLE;
               end
            end
            READ_DATA: begin
               b = snfcs_pkg::emit(b, snfcs_pkg::ACT_HOST, req_rx_byte, 1'b0);
               bytes_in = bytes_ff - 16'd1;
               if (bytes_in != 16'd0) begin
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RECV, 8'd0, 1'b0);
               end else begin
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_DONE, 8'd0, 1'b0);
                  phase_in = IDLE;
               end
            end
            default: begin
               eq = ideq_ff && (req_rx_byte == snfcs_pkg::ID_EXPECT[idc_ff]);
               ideq_in = eq;
               if (idc_ff < 2'd2) begin
                  idc_in = idc_ff + 2'd1;
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RECV, 8'd0, 1'b0);
               end else begin
                  idc_in = 2'd0;
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_RELEASE, 8'd0, 1'b0);
                  b = snfcs_pkg::emit(b, snfcs_pkg::ACT_DONE, 8'd0, eq);
                  phase_in = IDLE;
               end
            end
         endcase
      end else begin
         b = snfcs_pkg::emit(b, snfcs_pkg::ACT_REJECT, 8'd0, 1'b0);
      end
      batch = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= IDLE;
         op_ff <= '0;
         addr_ff <= '0;
         bytes_ff <= '0;
         blk_ff <= '0;
         brem_ff <= '0;
         idc_ff <= '0;
         ideq_ff <= 1'b1;
      end else if (accept) begin
         phase_ff <= phase_in;
         op_ff <= op_in;
         addr_ff <= addr_in;
         bytes_ff <= bytes_in;
         blk_ff <= blk_in;
         brem_ff <= brem_in;
         idc_ff <= idc_in;
         ideq_ff <= ideq_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/snfcs_queue.sv =====
`default_nettype none
module snfcs_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_en,
   input  wire snfcs_pkg::batch_type wr_data,
   output logic full,
   input  wire logic rd_en,
   output snfcs_pkg::batch_type rd_data,
   output logic empty
);
   snfcs_pkg::batch_type slot_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign rd_data = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr_en && !full) begin
            wp_ff <= !wp_ff;
         end
         if (rd_en && !empty) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + 2'((wr_en && !full) ? 1 : 0) - 2'((rd_en && !empty) ? 1 : 0);
      end
   end
endmodule
`default_nettype wire

// ===== hdl/snfcs_back.sv =====
`default_nettype none
module snfcs_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire snfcs_pkg::batch_type q_data,
   input  wire logic q_empty,
   output logic q_pop,
   output logic empty,
   input  wire logic pop,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_out_byte,
   output logic rsp_id_match,
   output logic rsp_last
);
   snfcs_pkg::batch_type cur_ff;
   logic busy_ff;
   logic [2:0] idx_ff;
   logic valid_ff;
   snfcs_pkg::result_type res_ff;
   logic last_ff;
   logic advance, is_last;

   assign q_pop = !busy_ff && !q_empty;
   assign advance = busy_ff && (!valid_ff || pop);
   assign is_last = 4'(idx_ff) + 4'd1 == cur_ff.count;
   assign empty = !valid_ff;
   assign rsp_action = res_ff.action;
   assign rsp_out_byte = res_ff.out_byte;
   assign rsp_id_match = res_ff.id_match;
   assign rsp_last = last_ff;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end
      if (advance) begin
         res_ff <= cur_ff.item[idx_ff];
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            busy_ff <= 1'b1;
            idx_ff <= '0;
         end else if (advance) begin
            idx_ff <= idx_ff + 3'd1;
            if (is_last) begin
               busy_ff <= 1'b0;
            end
         end
         if (advance) begin
            valid_ff <= 1'b1;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

// ===== hdl/spi_nor_flash_command_sequencer_core.sv =====
`default_nettype none
// Channel    Handshake              Payload
// request    push / full            req_type .. req_rx_byte
// response   pop / empty            rsp_action, rsp_out_byte, rsp_id_match, rsp_last
// csr        psel, penable, pready  paddr, pwdata, prdata
// A request is decoded in the cycle it is accepted and its whole batch of one to
// eight response beats enters a two-entry queue; the back end then issues one beat
// per cycle while pop keeps up, and holds a beat until it is popped.
// Requests are taken while the queue has room, independent of response stalls.
// Reset is synchronous and returns the registers to their default opcodes.
module spi_nor_flash_command_sequencer_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   output logic full,
   input  wire logic [3:0] req_type,
   input  wire logic [23:0] req_byte_address,
   input  wire logic [8:0] req_block_index,
   input  wire logic [9:0] req_block_count,
   input  wire logic [6:0] req_page_index,
   input  wire logic [15:0] req_transfer_length,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [7:0] req_rx_byte,
   output logic empty,
   input  wire logic pop,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_out_byte,
   output logic rsp_id_match,
   output logic rsp_last,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [4:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   snfcs_pkg::cfg_type cfg_ff;
   snfcs_pkg::batch_type batch, q_data;
   logic q_empty, q_pop, accept;

   assign pready = 1'b1;
   assign prdata = {24'd0, cfg_ff[paddr[4:2]]};
   assign accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= snfcs_pkg::CFG_RESET;
      end else if (psel && penable && pwrite) begin
         cfg_ff[paddr[4:2]] <= pwdata[7:0];
      end
   end

   snfcs_front u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .req_type(req_type), .req_byte_address(req_byte_address),
      .req_block_index(req_block_index), .req_block_count(req_block_count),
      .req_page_index(req_page_index), .req_transfer_length(req_transfer_length),
      .req_data_byte(req_data_byte), .req_rx_byte(req_rx_byte),
      .cfg(cfg_ff), .batch(batch)
   );

   snfcs_queue u_queue (
      .clock(clock), .reset(reset), .wr_en(push), .wr_data(batch), .full(full),
      .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
   );

   snfcs_back u_back (
      .clock(clock), .reset(reset), .q_data(q_data), .q_empty(q_empty), .q_pop(q_pop),
      .empty(empty), .pop(pop), .rsp_action(rsp_action), .rsp_out_byte(rsp_out_byte),
      .rsp_id_match(rsp_id_match), .rsp_last(rsp_last)
   );

   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_action == snfcs_pkg::ACT_REJECT) |-> rsp_last)
      else $error("reject beat not last");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_action == snfcs_pkg::ACT_DONE) |-> (rsp_last && rsp_out_byte == 8'd0))
      else $error("done beat malformed");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("response pending after reset");
endmodule
`default_nettype wire
